FILE: hw/rtl/msaa_pixel_coverage_depth_test_macros.svh
`ifndef MSAA_PIXEL_COVERAGE_DEPTH_TEST_MACROS_SVH
`define MSAA_PIXEL_COVERAGE_DEPTH_TEST_MACROS_SVH

// same-cycle implication, checked while out of reset
`define MSAA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked while out of reset
`define MSAA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/msaa_pkg.sv
`timescale 1ns / 1ps
package msaa_pkg;

  localparam int DEF_SCREEN_WIDTH  = 256;
  localparam int DEF_SCREEN_HEIGHT = 256;

  typedef struct packed {
    logic [7:0]         pixel_x;
    logic [7:0]         pixel_y;
    logic signed [15:0] vertex_a_x;
    logic signed [15:0] vertex_a_y;
    logic signed [15:0] vertex_b_x;
    logic signed [15:0] vertex_b_y;
    logic signed [15:0] vertex_c_x;
    logic signed [15:0] vertex_c_y;
    logic [23:0]        depth_a;
    logic [23:0]        depth_b;
    logic [23:0]        depth_c;
    logic [23:0]        tri_color;
  } in_item_t;

  typedef struct packed {
    logic        pixel_written;
    logic [2:0]  covered_count;
    logic [15:0] frame_index;
    logic [23:0] pixel_depth;
    logic [23:0] resolved_color;
  } out_item_t;

  // four samples of one pixel kept together in one memory word
  typedef struct packed {
    logic [3:0][23:0] depth;
    logic [3:0][23:0] color;
  } row_t;

  localparam logic [23:0] DEPTH_FAR = 24'hFFFFFF;
  localparam row_t ROW_RESET = '{depth: {4{DEPTH_FAR}}, color: '0};

endpackage

FILE: hw/rtl/msaa_pixel_coverage_depth_test.sv
`timescale 1ns / 1ps
// each request takes 15 multiply steps, 62 divide steps and one memory update; the divide
//   steps are skipped when the triangle has zero area
// one request at a time: the next is taken only after the result is registered, which
//   out_stall can hold off; one shared 19x25 multiplier and a one bit per cycle restoring divider
// reset: synchronous active-low; then a clearing pass writes far depth and black into
//   all SCREEN_WIDTH*SCREEN_HEIGHT sample memory words before in_stall drops
module msaa_pixel_coverage_depth_test
  import msaa_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  `include "msaa_pixel_coverage_depth_test_macros.svh"

  localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW     = $clog2(PIXELS);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_MUL, S_DIV, S_FIN} state_t;

  state_t             state_r;
  logic [AW-1:0]      clr_cnt_r;
  in_item_t           item_r;
  logic               in_range_r;
  logic [15:0]        idx_r;
  logic [AW-1:0]      addr_r;
  logic [3:0]         k_r;
  logic signed [43:0] prod_r;
  logic signed [61:0] acc_r;
  logic signed [35:0] area_r, e_bc_r, e_ca_r, e_ab_r;
  logic [3:0]         cover_r;
  logic [61:0]        quo_r;
  logic [35:0]        rem_r, den_r;
  logic               neg_r;
  logic [5:0]         div_cnt_r;
  logic [23:0]        depth_r;
  row_t               rd_row_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  row_t sample_mem [PIXELS];

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  row_t          mem_wdata;

  // ---------------- operand selection for the shared multiplier
  logic signed [17:0] ax, ay, bx, by, cx, cy, qx, qy;
  logic signed [18:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [43:0] mul_p;

  function automatic logic signed [18:0] w_lo(input logic signed [35:0] w);
    w_lo = $signed({1'b0, w[17:0]});
  endfunction

  function automatic logic signed [18:0] w_hi(input logic signed [35:0] w);
    w_hi = 19'($signed(w[35:18]));
  endfunction

  always_comb begin
    ax = 18'(item_r.vertex_a_x);
    ay = 18'(item_r.vertex_a_y);
    bx = 18'(item_r.vertex_b_x);
    by = 18'(item_r.vertex_b_y);
    cx = 18'(item_r.vertex_c_x);
    cy = 18'(item_r.vertex_c_y);
    qx = $signed({6'b0, item_r.pixel_x, 4'b0});
    qy = $signed({6'b0, item_r.pixel_y, 4'b0});
    mul_a = '0;
    mul_b = '0;
    case (k_r)
      4'd0: begin mul_a = 19'(bx - ax); mul_b = 25'(cy - ay); end
      4'd1: begin mul_a = 19'(by - ay); mul_b = 25'(cx - ax); end
      4'd2: begin mul_a = 19'(cx - bx); mul_b = 25'(qy - by); end
      4'd3: begin mul_a = 19'(cy - by); mul_b = 25'(qx - bx); end
      4'd4: begin mul_a = 19'(ax - cx); mul_b = 25'(qy - cy); end
      4'd5: begin mul_a = 19'(ay - cy); mul_b = 25'(qx - cx); end
      4'd6: begin mul_a = 19'(bx - ax); mul_b = 25'(qy - ay); end
      4'd7: begin mul_a = 19'(by - ay); mul_b = 25'(qx - ax); end
      4'd8: begin mul_a = w_lo(e_bc_r); mul_b = $signed({1'b0, item_r.depth_a}); end
      4'd9: begin mul_a = w_hi(e_bc_r); mul_b = $signed({1'b0, item_r.depth_a}); end
      4'd10: begin mul_a = w_lo(e_ca_r); mul_b = $signed({1'b0, item_r.depth_b}); end
      4'd11: begin mul_a = w_hi(e_ca_r); mul_b = $signed({1'b0, item_r.depth_b}); end
      4'd12: begin mul_a = w_lo(e_ab_r); mul_b = $signed({1'b0, item_r.depth_c}); end
      4'd13: begin mul_a = w_hi(e_ab_r); mul_b = $signed({1'b0, item_r.depth_c}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    mul_p = mul_a * mul_b;
  end

  // ---------------- accumulate the product of the previous step
  logic [3:0]         prev_k;
  logic signed [61:0] term, acc_nxt;

  always_comb begin
    prev_k = k_r - 4'd1;
    term   = 62'(prod_r);
    if (prev_k == 4'd9 || prev_k == 4'd11 || prev_k == 4'd13) begin
      term = term <<< 18;
    end
    if (prev_k < 4'd8 && prev_k[0]) begin
      acc_nxt = acc_r - term;
    end else begin
      acc_nxt = acc_r + term;
    end
  end

  // ---------------- coverage of the four samples from corner edge values
  logic [3:0] cover_nxt;

  function automatic logic edge_neg(input logic signed [35:0] e,
                                    input logic signed [17:0] dx_edge,
                                    input logic signed [17:0] dy_edge,
                                    input logic step_x, input logic step_y);
    logic signed [35:0] v;
    v = e;
    if (step_y) v = v + (36'(dx_edge) <<< 3);
    if (step_x) v = v - (36'(dy_edge) <<< 3);
    edge_neg = v[35];
  endfunction

  always_comb begin
    logic n0, n1, n2;
    for (int s = 0; s < 4; s++) begin
      n0 = edge_neg(e_ab_r, 18'(bx - ax), 18'(by - ay), s[1], s[0]);
      n1 = edge_neg(e_bc_r, 18'(cx - bx), 18'(cy - by), s[1], s[0]);
      n2 = edge_neg(e_ca_r, 18'(ax - cx), 18'(ay - cy), s[1], s[0]);
      cover_nxt[s] = (n0 == n1) && (n1 == n2);
    end
  end

  // ---------------- divider step
  logic [36:0] trial;
  logic        ge;
  logic [61:0] q_fin;

  always_comb begin
    trial = {rem_r, quo_r[61]};
    ge    = trial >= {1'b0, den_r};
    q_fin = {quo_r[60:0], ge};
  end

  // ---------------- final depth test and resolve
  logic [3:0]  pass;
  row_t        new_row;
  logic [2:0]  count;
  logic [9:0]  sum_r, sum_g, sum_b;
  logic        fire;
  out_item_t   result;

  always_comb begin
    new_row = rd_row_r;
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int s = 0; s < 4; s++) begin
      pass[s] = in_range_r && cover_r[s] && (area_r != '0) && (depth_r < rd_row_r.depth[s]);
      if (pass[s]) begin
        new_row.depth[s] = depth_r;
        new_row.color[s] = item_r.tri_color;
      end
      sum_r = sum_r + 10'(new_row.color[s][23:16]);
      sum_g = sum_g + 10'(new_row.color[s][15:8]);
      sum_b = sum_b + 10'(new_row.color[s][7:0]);
    end
    count = 3'(pass[0]) + 3'(pass[1]) + 3'(pass[2]) + 3'(pass[3]);
    result = '0;
    if (in_range_r) begin
      result.pixel_written  = count != 3'd0;
      result.covered_count  = count;
      result.frame_index    = idx_r;
      result.pixel_depth    = depth_r;
      result.resolved_color = {sum_r[9:2], sum_g[9:2], sum_b[9:2]};
    end
    fire = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  end

  // ---------------- memory port
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = (state_r == S_MUL) && (k_r == 4'd0);
    mem_addr  = addr_r;
    mem_wdata = new_row;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_addr  = clr_cnt_r;
      mem_wdata = ROW_RESET;
    end else if (fire && pass != 4'b0) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sample_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_row_r <= sample_mem[addr_r];
    end
  end

  // ---------------- input address math
  logic [31:0] idx_full;
  logic        in_range_nxt;

  always_comb begin
    in_range_nxt = (int'(in_data.pixel_x) < SCREEN_WIDTH) &&
                   (int'(in_data.pixel_y) < SCREEN_HEIGHT);
    idx_full = 32'((SCREEN_HEIGHT - 1 - int'(in_data.pixel_y)) * SCREEN_WIDTH
                   + int'(in_data.pixel_x));
  end

  // ---------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      div_cnt_r   <= '0;
    end else begin
      if (out_valid_r && !out_stall && !fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == AW'(PIXELS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item_r     <= in_data;
            in_range_r <= in_range_nxt;
            idx_r      <= idx_full[15:0];
            addr_r     <= idx_full[AW-1:0];
            k_r        <= '0;
            acc_r      <= '0;
            state_r    <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r <= mul_p;
          k_r    <= k_r + 4'd1;
          if (k_r != 4'd0) begin
            if (prev_k < 4'd8 && prev_k[0]) begin
              acc_r <= '0;
              unique case (prev_k)
                4'd1: area_r <= 36'(acc_nxt);
                4'd3: e_bc_r <= 36'(acc_nxt);
                4'd5: e_ca_r <= 36'(acc_nxt);
                default: e_ab_r <= 36'(acc_nxt);
              endcase
            end else begin
              acc_r <= acc_nxt;
            end
          end
          if (k_r == 4'd14) begin
            cover_r <= cover_nxt;
            if (area_r == '0) begin
              depth_r <= '0;
              state_r <= S_FIN;
            end else begin
              neg_r     <= acc_nxt[61] ^ area_r[35];
              quo_r     <= acc_nxt[61] ? 62'(-acc_nxt) : 62'(acc_nxt);
              den_r     <= area_r[35] ? 36'(-area_r) : 36'(area_r);
              rem_r     <= '0;
              div_cnt_r <= '0;
              state_r   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_r     <= ge ? 36'(trial - {1'b0, den_r}) : trial[35:0];
          quo_r     <= q_fin;
          div_cnt_r <= div_cnt_r + 6'd1;
          if (div_cnt_r == 6'd61) begin
            // truncation toward zero, then clamp to the depth range
            if (neg_r) begin
              depth_r <= '0;
            end else if (|q_fin[61:24]) begin
              depth_r <= DEPTH_FAR;
            end else begin
              depth_r <= q_fin[23:0];
            end
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (fire) begin
            out_valid_r <= 1'b1;
            out_data_r  <= result;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MSAA_ASSERT_NOW(a_busy_stalls, state_r != S_IDLE, in_stall, "request taken while busy")
  `MSAA_ASSERT_NOW(a_write_needs_pass, mem_we && state_r != S_CLEAR, in_range_r && pass != 4'b0, "sample write without a passing sample")
  `MSAA_ASSERT_NEXT(a_div_exit, state_r == S_DIV, state_r == S_DIV || state_r == S_FIN, "divider left to wrong state")
  `MSAA_ASSERT_NEXT(a_fin_result, fire, out_valid_r, "finished request produced no result")

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import msaa_pkg::*;

  localparam int SCR_W = 256;
  localparam int SCR_H = 256;
  localparam int SLOTS = SCR_W * SCR_H * 4;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int HOLD_CYCLES = 3000;
  localparam int RANDOM_ITEMS = 520;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;

  msaa_pixel_coverage_depth_test dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // predictor copy of the sample stores
  logic [23:0] sample_z[SLOTS];
  logic [23:0] sample_rgb[SLOTS];

  out_item_t pending_pixels[$];
  int n_sent, n_checked, n_written, n_zero_area, n_mismatch;
  int burst_left;
  int idle_cycles;
  bit hold_req;

  function automatic longint edge_val(longint x0, longint y0, longint x1, longint y1,
                                      longint qx, longint qy);
    return (x1 - x0) * (qy - y0) - (y1 - y0) * (qx - x0);
  endfunction

  function automatic out_item_t shade_pixel(in_item_t it);
    out_item_t res;
    longint ax, ay, bx, by, cx, cy, area2, qx0, qy0, w0, w1, w2, q, qx, qy;
    int unsigned idx, slot, cnt, r, g, b;
    logic [23:0] z;
    bit n0, n1, n2;
    ax = it.vertex_a_x; ay = it.vertex_a_y;
    bx = it.vertex_b_x; by = it.vertex_b_y;
    cx = it.vertex_c_x; cy = it.vertex_c_y;
    idx = (SCR_H - 1 - it.pixel_y) * SCR_W + it.pixel_x;
    area2 = edge_val(ax, ay, bx, by, cx, cy);
    qx0 = longint'(it.pixel_x) * 16;
    qy0 = longint'(it.pixel_y) * 16;
    z = '0;
    cnt = 0;
    if (area2 != 0) begin
      w0 = edge_val(bx, by, cx, cy, qx0, qy0);
      w1 = edge_val(cx, cy, ax, ay, qx0, qy0);
      w2 = edge_val(ax, ay, bx, by, qx0, qy0);
      q = (w0 * longint'(it.depth_a) + w1 * longint'(it.depth_b)
           + w2 * longint'(it.depth_c)) / area2;
      if (q < 0) q = 0;
      if (q > 64'hFFFFFF) q = 64'hFFFFFF;
      z = q[23:0];
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          qx = qx0 + 8 * i;
          qy = qy0 + 8 * j;
          slot = idx * 4 + i * 2 + j;
          n0 = edge_val(ax, ay, bx, by, qx, qy) < 0;
          n1 = edge_val(bx, by, cx, cy, qx, qy) < 0;
          n2 = edge_val(cx, cy, ax, ay, qx, qy) < 0;
          if (n0 == n1 && n1 == n2 && z < sample_z[slot]) begin
            sample_z[slot] = z;
            sample_rgb[slot] = it.tri_color;
            cnt++;
          end
        end
      end
    end
    r = 0; g = 0; b = 0;
    for (int k = 0; k < 4; k++) begin
      r += sample_rgb[idx * 4 + k][23:16];
      g += sample_rgb[idx * 4 + k][15:8];
      b += sample_rgb[idx * 4 + k][7:0];
    end
    res.pixel_written = cnt > 0;
    res.covered_count = cnt[2:0];
    res.frame_index = idx[15:0];
    res.pixel_depth = z;
    res.resolved_color = {8'(r / 4), 8'(g / 4), 8'(b / 4)};
    return res;
  endfunction

  // valid stays high across a burst, drops only for a gap
  task automatic send_pixel(in_item_t it);
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (edge_val(it.vertex_a_x, it.vertex_a_y, it.vertex_b_x, it.vertex_b_y,
                 it.vertex_c_x, it.vertex_c_y) == 0)
      n_zero_area++;
    pending_pixels.push_back(shade_pixel(it));
    n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
    end
  endtask

  function automatic in_item_t make_tri(int ax, int ay, int bx, int by, int cx, int cy,
                                        int za, int zb, int zc, int rgb);
    in_item_t it;
    it.pixel_x = '0; it.pixel_y = '0;
    it.vertex_a_x = 16'(ax); it.vertex_a_y = 16'(ay);
    it.vertex_b_x = 16'(bx); it.vertex_b_y = 16'(by);
    it.vertex_c_x = 16'(cx); it.vertex_c_y = 16'(cy);
    it.depth_a = 24'(za); it.depth_b = 24'(zb); it.depth_c = 24'(zc);
    it.tri_color = 24'(rgb);
    return it;
  endfunction

  task automatic send_at(in_item_t it, int px, int py);
    it.pixel_x = 8'(px);
    it.pixel_y = 8'(py);
    send_pixel(it);
  endtask

  // walk the bounding box of a triangle like the feeder does
  task automatic raster_tri(in_item_t it);
    int x0, x1, y0, y1;
    x0 = it.vertex_a_x >>> 4; x1 = x0;
    y0 = it.vertex_a_y >>> 4; y1 = y0;
    x0 = (it.vertex_b_x >>> 4) < x0 ? (it.vertex_b_x >>> 4) : x0;
    x0 = (it.vertex_c_x >>> 4) < x0 ? (it.vertex_c_x >>> 4) : x0;
    x1 = (it.vertex_b_x >>> 4) > x1 ? (it.vertex_b_x >>> 4) : x1;
    x1 = (it.vertex_c_x >>> 4) > x1 ? (it.vertex_c_x >>> 4) : x1;
    y0 = (it.vertex_b_y >>> 4) < y0 ? (it.vertex_b_y >>> 4) : y0;
    y0 = (it.vertex_c_y >>> 4) < y0 ? (it.vertex_c_y >>> 4) : y0;
    y1 = (it.vertex_b_y >>> 4) > y1 ? (it.vertex_b_y >>> 4) : y1;
    y1 = (it.vertex_c_y >>> 4) > y1 ? (it.vertex_c_y >>> 4) : y1;
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > SCR_W - 1) x1 = SCR_W - 1;
    if (y1 > SCR_H - 1) y1 = SCR_H - 1;
    for (int y = y0; y <= y1; y++)
      for (int x = x0; x <= x1; x++)
        send_at(it, x, y);
  endtask

  task automatic test_directed();
    in_item_t big, flat, clamp;
    big = make_tri(-32768, -32768, 32767, -32768, 0, 32767, 0, 24'hFFFFFF, 24'h800000,
                   24'hFFFFFF);
    send_at(big, 0, 0);
    send_at(big, 255, 255);
    send_at(big, 128, 0);
    send_at(big, 0, 255);
    // opposite winding over the same corner, nearer
    send_at(make_tri(0, 0, 0, 32767, 32767, 0, 0, 0, 0, 24'h000000), 0, 0);
    // zero area: collinear vertices
    flat = make_tri(16, 16, 160, 160, 320, 320, 5, 5, 5, 24'h123456);
    send_at(flat, 5, 5);
    send_at(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 24'hFFFFFF), 0, 0);
    // depth all far never passes
    send_at(make_tri(1600, 1600, 1760, 1600, 1600, 1760, 24'hFFFFFF, 24'hFFFFFF,
                     24'hFFFFFF, 24'hABCDEF), 101, 101);
    // extrapolation outside the triangle clamps high and low
    clamp = make_tri(800, 800, 832, 800, 800, 832, 0, 24'hFFFFFF, 24'hFFFFFF, 24'h0F0F0F);
    send_at(clamp, 60, 60);
    send_at(clamp, 40, 40);
    send_at(clamp, 50, 50);
    // small triangle walked fully, then a nearer one on top, then a farther one
    raster_tri(make_tri(1616, 1616, 1680, 1616, 1616, 1680, 100, 100, 100, 24'hFF0000));
    raster_tri(make_tri(1616, 1616, 1616, 1680, 1680, 1616, 50, 60, 70, 24'h00FF00));
    raster_tri(make_tri(1616, 1616, 1680, 1680, 1616, 1680, 9000, 9000, 9000, 24'h0000FF));
  endtask

  function automatic in_item_t rand_tri(bit crowded);
    int bx, by;
    in_item_t it;
    bx = crowded ? $urandom_range(96, 108) * 16 : $urandom_range(0, 250) * 16;
    by = crowded ? $urandom_range(96, 108) * 16 : $urandom_range(0, 250) * 16;
    it = make_tri(bx + $urandom_range(0, 96), by + $urandom_range(0, 96),
                  bx + $urandom_range(0, 96), by + $urandom_range(0, 96),
                  bx + $urandom_range(0, 96), by + $urandom_range(0, 96),
                  $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                  $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF));
    if ($urandom_range(0, 3) == 0) begin
      it.depth_b = it.depth_a;
      it.depth_c = it.depth_a;
    end
    return it;
  endfunction

  function automatic in_item_t rand_noise();
    in_item_t it;
    it.pixel_x = 8'($urandom); it.pixel_y = 8'($urandom);
    it.vertex_a_x = 16'($urandom); it.vertex_a_y = 16'($urandom);
    it.vertex_b_x = 16'($urandom); it.vertex_b_y = 16'($urandom);
    it.vertex_c_x = 16'($urandom); it.vertex_c_y = 16'($urandom);
    it.depth_a = 24'($urandom); it.depth_b = 24'($urandom); it.depth_c = 24'($urandom);
    it.tri_color = 24'($urandom);
    return it;
  endfunction

  task automatic test_random();
    int goal;
    goal = n_sent + RANDOM_ITEMS;
    while (n_sent < goal) begin
      if ($urandom_range(0, 9) == 0) send_pixel(rand_noise());
      else raster_tri(rand_tri($urandom_range(0, 2) != 0));
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int k = 0; k < 30; k++) send_pixel(rand_tri(1'b1));
  endtask

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int mode, left;
    out_stall = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(50, 400);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = pending_pixels.pop_front();
        n_checked++;
        if (out_data.pixel_written) n_written++;
        if (out_data.pixel_written !== want.pixel_written
            || out_data.covered_count !== want.covered_count
            || out_data.frame_index !== want.frame_index
            || out_data.pixel_depth !== want.pixel_depth
            || out_data.resolved_color !== want.resolved_color) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch at result %0d: expected %p got %p", n_checked, want, out_data);
        end
      end
    end
  end

  // watchdog on cycles without any handshake; covers the clearing pass
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired: %0d pending", pending_pixels.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    hold_req = 1'b0;
    idle_cycles = 0;
    burst_left = 0;
    for (int k = 0; k < SLOTS; k++) begin
      sample_z[k] = DEPTH_FAR;
      sample_rgb[k] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d pixel requests, checked %0d results, %0d written, %0d zero-area",
             n_sent, n_checked, n_written, n_zero_area);
    if (n_mismatch == 0 && pending_pixels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
